### rtl/core/vrot_pkg.sv
// Shared types and constants for the vertex rotation block.
// No dependencies; imported by vrot_trig, vrot_pipe and axis_vertex_rotation.
package vrot_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int ANGLE_BITS_DEF = 16;

  // Q1.14 sine/cosine
  localparam int TRIG_BITS = 16;
  localparam int TRIG_FRAC = 14;

  // quarter-wave polynomial
  localparam logic [14:0] QS_ONE = 15'd16384;
  localparam logic [11:0] QS_K2  = 12'd2320;
  localparam logic [14:0] QS_K1  = 15'd21024;
  localparam logic [15:0] QS_K3  = 16'd51472;

  typedef enum logic [1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_Z    = 2'd2,
    AXIS_NONE = 2'd3
  } axis_t;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  typedef enum logic {
    REG_ANGLE = 1'b0,
    REG_AXIS  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic                        busy;
    logic signed [TRIG_BITS-1:0] cos_v;
    logic signed [TRIG_BITS-1:0] sin_v;
  } trig_t;

endpackage

### rtl/core/vrot_trig.sv
// Sine/cosine unit: four-stage pipelined quarter-wave polynomial, two lanes.
// Depends on vrot_pkg.
module vrot_trig #(
  parameter int ANGLE_BITS = vrot_pkg::ANGLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [ANGLE_BITS-1:0] angle,
  output vrot_pkg::trig_t       trig
);
  import vrot_pkg::*;

  logic [15:0] a16;

  generate
    if (ANGLE_BITS >= 16) begin : g_down
      assign a16 = angle[ANGLE_BITS-1 -: 16];
    end else begin : g_up
      assign a16 = {angle, {(16-ANGLE_BITS){1'b0}}};
    end
  endgenerate

  // lane 0: phase r, lane 1: complement 16384 - r
  logic        v0_r, v1_r, v2_r, v3_r;
  quad_t       q0_r, q1_r, q2_r, q3_r;
  logic [14:0] z0_r [2];
  logic [14:0] z1_r [2];
  logic [14:0] z2_r [2];
  logic [14:0] z3_r [2];
  logic [14:0] sq1_r [2];
  logic [14:0] sq2_r [2];
  logic [14:0] t2_r [2];
  logic [15:0] t3_r [2];

  logic [29:0] m1 [2];
  logic [25:0] m2 [2];
  logic [28:0] m3 [2];
  logic [29:0] m4 [2];
  logic signed [TRIG_BITS-1:0] s_val [2];

  logic signed [TRIG_BITS-1:0] sin_r, sin_nxt;
  logic signed [TRIG_BITS-1:0] cos_r, cos_nxt;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      m1[i] = 30'(z0_r[i]) * 30'(z0_r[i]);
      m2[i] = 26'(QS_K2) * 26'(sq1_r[i]);
      m3[i] = 29'(t2_r[i]) * 29'(sq2_r[i]);
      m4[i] = 30'(z3_r[i]) * 30'(t3_r[i]);
      s_val[i] = signed'({1'b0, m4[i][29:15]});
    end
  end

  always_comb begin
    sin_nxt = sin_r;
    cos_nxt = cos_r;
    if (v3_r) begin
      case (q3_r)
        QUAD_0: begin
          sin_nxt = s_val[0];
          cos_nxt = s_val[1];
        end
        QUAD_1: begin
          sin_nxt = s_val[1];
          cos_nxt = -s_val[0];
        end
        QUAD_2: begin
          sin_nxt = -s_val[0];
          cos_nxt = -s_val[1];
        end
        default: begin
          sin_nxt = -s_val[1];
          cos_nxt = s_val[0];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r  <= 1'b0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      sin_r <= '0;
      cos_r <= signed'({1'b0, QS_ONE});
    end else begin
      v0_r  <= start;
      v1_r  <= v0_r;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      sin_r <= sin_nxt;
      cos_r <= cos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q0_r    <= quad_t'(a16[15:14]);
    z0_r[0] <= {1'b0, a16[13:0]};
    z0_r[1] <= QS_ONE - {1'b0, a16[13:0]};
    q1_r    <= q0_r;
    q2_r    <= q1_r;
    q3_r    <= q2_r;
    for (int i = 0; i < 2; i++) begin
      z1_r[i]  <= z0_r[i];
      sq1_r[i] <= m1[i][28:14];
      z2_r[i]  <= z1_r[i];
      sq2_r[i] <= sq1_r[i];
      t2_r[i]  <= QS_K1 - {3'b0, m2[i][25:14]};
      z3_r[i]  <= z2_r[i];
      t3_r[i]  <= QS_K3 - {1'b0, m3[i][28:14]};
    end
  end

  assign trig.busy  = v0_r | v1_r | v2_r | v3_r;
  assign trig.sin_v = sin_r;
  assign trig.cos_v = cos_r;

endmodule

### rtl/core/vrot_pipe.sv
// Rotation datapath: operand select, multiply, add, round/saturate stages.
// Depends on vrot_pkg.
module vrot_pipe #(
  parameter int COORD_BITS = vrot_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_x,
  input  logic signed [COORD_BITS-1:0] in_y,
  input  logic signed [COORD_BITS-1:0] in_z,
  input  vrot_pkg::axis_t              axis,
  input  vrot_pkg::trig_t              trig,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] out_x,
  output logic signed [COORD_BITS-1:0] out_y,
  output logic signed [COORD_BITS-1:0] out_z
);
  import vrot_pkg::*;

  localparam int PW = COORD_BITS + TRIG_BITS;
  localparam int SW = PW + 1;
  localparam int QW = SW - TRIG_FRAC;
  localparam logic signed [QW-1:0] QMAX =
    signed'({{(QW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}});
  localparam logic signed [QW-1:0] QMIN = ~QMAX;
  localparam logic signed [SW-1:0] HALF = SW'(1) <<< (TRIG_FRAC - 1);

  logic rdy1, rdy2, rdy3, rdy4;
  logic v1_r, v2_r, v3_r, vo_r;

  axis_t ax1_r, ax2_r, ax3_r;
  logic signed [COORD_BITS-1:0] x1_r, y1_r, z1_r, x2_r, y2_r, z2_r, x3_r, y3_r, z3_r;
  logic signed [COORD_BITS-1:0] a1_r, b1_r;
  logic signed [PW-1:0] ac_r, bs_r, as_r, bc_r;
  logic signed [SW-1:0] su_r, sv_r;
  logic signed [COORD_BITS-1:0] ox_r, oy_r, oz_r;
  logic signed [COORD_BITS-1:0] ox_nxt, oy_nxt, oz_nxt;

  logic signed [COORD_BITS-1:0] a_sel, b_sel;
  logic signed [QW-1:0] qu, qv;
  logic signed [COORD_BITS-1:0] nu, nv;

  assign rdy4     = !vo_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // rotated pair: nu = a*c - b*s, nv = a*s + b*c
  always_comb begin
    case (axis)
      AXIS_X: begin
        a_sel = in_y;
        b_sel = in_z;
      end
      AXIS_Y: begin
        a_sel = in_z;
        b_sel = in_x;
      end
      default: begin
        a_sel = in_x;
        b_sel = in_y;
      end
    endcase
  end

  always_comb begin
    qu = QW'(su_r >>> TRIG_FRAC);
    qv = QW'(sv_r >>> TRIG_FRAC);
    if (qu > QMAX) begin
      nu = QMAX[COORD_BITS-1:0];
    end else if (qu < QMIN) begin
      nu = QMIN[COORD_BITS-1:0];
    end else begin
      nu = qu[COORD_BITS-1:0];
    end
    if (qv > QMAX) begin
      nv = QMAX[COORD_BITS-1:0];
    end else if (qv < QMIN) begin
      nv = QMIN[COORD_BITS-1:0];
    end else begin
      nv = qv[COORD_BITS-1:0];
    end
    ox_nxt = x3_r;
    oy_nxt = y3_r;
    oz_nxt = z3_r;
    case (ax3_r)
      AXIS_X: begin
        oy_nxt = nu;
        oz_nxt = nv;
      end
      AXIS_Y: begin
        oz_nxt = nu;
        ox_nxt = nv;
      end
      AXIS_Z: begin
        ox_nxt = nu;
        oy_nxt = nv;
      end
      default: begin
        ox_nxt = x3_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdy4) begin
        vo_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      ax1_r <= axis;
      x1_r  <= in_x;
      y1_r  <= in_y;
      z1_r  <= in_z;
      a1_r  <= a_sel;
      b1_r  <= b_sel;
    end
    if (rdy2) begin
      ax2_r <= ax1_r;
      x2_r  <= x1_r;
      y2_r  <= y1_r;
      z2_r  <= z1_r;
      ac_r  <= PW'(a1_r) * PW'(trig.cos_v);
      bs_r  <= PW'(b1_r) * PW'(trig.sin_v);
      as_r  <= PW'(a1_r) * PW'(trig.sin_v);
      bc_r  <= PW'(b1_r) * PW'(trig.cos_v);
    end
    if (rdy3) begin
      ax3_r <= ax2_r;
      x3_r  <= x2_r;
      y3_r  <= y2_r;
      z3_r  <= z2_r;
      su_r  <= SW'(ac_r) - SW'(bs_r) + HALF;
      sv_r  <= SW'(as_r) + SW'(bc_r) + HALF;
    end
    if (rdy4) begin
      ox_r <= ox_nxt;
      oy_r <= oy_nxt;
      oz_r <= oz_nxt;
    end
  end

  assign out_valid = vo_r;
  assign out_x     = ox_r;
  assign out_y     = oy_r;
  assign out_z     = oz_r;

endmodule

### rtl/core/axis_vertex_rotation.sv
// Vertex rotation about one principal axis, stream in and stream out.
// Operand select, multiply, add, round/saturate stages; one vertex per cycle while
// out_tready is high. An angle write recomputes sine/cosine and holds input off.
// Synchronous active-low reset: angle 0 (cos 1.0, sin 0), axis X, pipeline empty.
// Depends on vrot_pkg, vrot_trig, vrot_pipe.
module axis_vertex_rotation #(
  parameter int COORD_BITS = vrot_pkg::COORD_BITS_DEF,
  parameter int ANGLE_BITS = vrot_pkg::ANGLE_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  input  logic [((3*COORD_BITS+7)/8)*8-1:0]       in_tdata,  // x, y, z
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  output logic [((3*COORD_BITS+7)/8)*8-1:0]       out_tdata, // x, y, z
  input  logic                                    cfg_wr_en,
  input  vrot_pkg::reg_idx_t                      cfg_index,
  input  logic [ANGLE_BITS-1:0]                   cfg_data
);
  import vrot_pkg::*;

  localparam int DW  = ((3*COORD_BITS+7)/8)*8;
  localparam int PAD = DW - 3*COORD_BITS;

  axis_t axis_r, axis_nxt;
  trig_t trig;
  logic  angle_wr;
  logic  pipe_ready;
  logic  pipe_valid;
  logic signed [COORD_BITS-1:0] ox, oy, oz;

  assign angle_wr = cfg_wr_en && (cfg_index == REG_ANGLE);

  always_comb begin
    axis_nxt = axis_r;
    if (cfg_wr_en && (cfg_index == REG_AXIS)) begin
      axis_nxt = axis_t'(cfg_data[1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_r <= AXIS_X;
    end else begin
      axis_r <= axis_nxt;
    end
  end

  vrot_trig #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_trig (
    .clk   (clk),
    .rst_n (rst_n),
    .start (angle_wr),
    .angle (cfg_data),
    .trig  (trig)
  );

  assign in_tready  = pipe_ready && !trig.busy && !angle_wr;
  assign pipe_valid = in_tvalid && !trig.busy && !angle_wr;

  vrot_pipe #(
    .COORD_BITS(COORD_BITS)
  ) u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pipe_valid),
    .in_ready  (pipe_ready),
    .in_x      (signed'(in_tdata[COORD_BITS-1:0])),
    .in_y      (signed'(in_tdata[2*COORD_BITS-1:COORD_BITS])),
    .in_z      (signed'(in_tdata[3*COORD_BITS-1:2*COORD_BITS])),
    .axis      (axis_r),
    .trig      (trig),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_x     (ox),
    .out_y     (oy),
    .out_z     (oz)
  );

  generate
    if (PAD > 0) begin : g_pad
      assign out_tdata = {{PAD{1'b0}}, oz, oy, ox};
    end else begin : g_nopad
      assign out_tdata = {oz, oy, ox};
    end
  endgenerate

  // no vertex enters while sine/cosine are being recomputed
  a_no_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
    trig.busy |-> !(in_tvalid && in_tready))
    else $error("vertex accepted during trig update");

  a_angle_starts_trig : assert property (@(posedge clk) disable iff (!rst_n)
    angle_wr |=> trig.busy)
    else $error("angle write did not start trig update");

  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

### tb/sv/axis_vertex_rotation_tb.sv
// Self-checking testbench for axis_vertex_rotation: directed vectors, then random vertices
// under several rotation settings, checked against table rows or a local rotation predictor.
// Depends on vrot_pkg and the axis_vertex_rotation RTL.
module axis_vertex_rotation_tb;
  import vrot_pkg::*;

  // packed so that x sits in the low bits of tdata
  typedef struct packed {
    logic signed [15:0] z;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } vertex_t;

  typedef struct packed {
    logic        wr;
    logic [15:0] angle;
    logic [15:0] axis_word;
    vertex_t     v;
    logic        known;
    vertex_t     want;
  } dir_row_t;

  localparam int N_DIR = 19;
  localparam vertex_t NOV = '0;

  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    // reset setting: angle 0, axis X -> identity
    '{1'b0, 16'h0000, 16'h0000, '{16'h0001, 16'h8000, 16'h7FFF}, 1'b1,
      '{16'h0001, 16'h8000, 16'h7FFF}},
    '{1'b0, 16'h0000, 16'h0000, '{16'hFFFF, 16'h7FFF, 16'h8000}, 1'b1,
      '{16'hFFFF, 16'h7FFF, 16'h8000}},
    '{1'b0, 16'h0000, 16'h0000, NOV, 1'b1, NOV},
    // no-rotation axis, upper bits of the axis word set
    '{1'b1, 16'h4000, 16'hFFFF, '{16'h7FFF, -16'sd5, 16'sd1234}, 1'b1,
      '{16'h7FFF, -16'sd5, 16'sd1234}},
    // quarter turn about Z, saturating
    '{1'b1, 16'h4000, 16'h0002, '{16'sd7, 16'h8000, 16'sd100}, 1'b1,
      '{16'sd7, 16'sd100, 16'h7FFF}},
    '{1'b0, 16'h4000, 16'h0002, '{16'h0000, 16'h7FFF, 16'h8000}, 1'b1,
      '{16'h0000, 16'h8000, 16'h8001}},
    // quarter turn about X and Y
    '{1'b1, 16'h4000, 16'h0000, '{16'h8000, 16'sd256, 16'sd5}, 1'b1,
      '{16'sd256, 16'h7FFF, 16'sd5}},
    '{1'b1, 16'h4000, 16'h0001, '{16'hFFFF, 16'sd3, 16'h8000}, 1'b1,
      '{16'h7FFF, 16'sd3, 16'hFFFF}},
    // half turn about X
    '{1'b1, 16'h8000, 16'h0000, '{16'hFFFF, 16'sd1, 16'sd0}, 1'b1,
      '{16'sd1, 16'hFFFF, 16'sd0}},
    '{1'b0, 16'h8000, 16'h0000, '{16'h7FFF, 16'h8000, 16'sd9}, 1'b1,
      '{16'h8001, 16'h7FFF, 16'sd9}},
    // three quarters about Z
    '{1'b1, 16'hC000, 16'h0002, '{16'sd9, -16'sd300, 16'sd200}, 1'b1,
      '{16'sd9, -16'sd200, -16'sd300}},
    // remaining rows go through the predictor
    '{1'b1, 16'hFFFF, 16'h0002, '{16'h7FFF, 16'h7FFF, 16'h7FFF}, 1'b0, NOV},
    '{1'b0, 16'hFFFF, 16'h0002, '{16'h8000, 16'h8000, 16'h8000}, 1'b0, NOV},
    '{1'b1, 16'h0001, 16'h0001, '{16'h8000, 16'h7FFF, 16'h8000}, 1'b0, NOV},
    '{1'b1, 16'h2000, 16'h0000, '{16'sd1, 16'sd1, 16'sd0}, 1'b0, NOV},
    '{1'b0, 16'h2000, 16'h0000, '{16'h7FFF, 16'hFFFF, 16'h0000}, 1'b0, NOV},
    '{1'b1, 16'h6000, 16'h0001, '{16'h5555, 16'hAAAA, 16'h0155}, 1'b0, NOV},
    '{1'b1, 16'h3FFF, 16'h0002, '{16'h0000, 16'h5555, 16'hAAAA}, 1'b0, NOV},
    // angle 0 about Z, stray upper axis bits
    '{1'b1, 16'h0000, 16'hFFFE, '{16'h0001, 16'hFF80, 16'h0080}, 1'b1,
      '{16'h0001, 16'hFF80, 16'h0080}}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;  // x, y, z
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;      // x, y, z
  logic        cfg_wr_en = 1'b0;
  reg_idx_t    cfg_index = REG_ANGLE;
  logic [15:0] cfg_data = '0;

  // rotation state as the block should hold it
  axis_t              axis_sel = AXIS_X;
  logic signed [15:0] cos_q14 = 16'sd16384;
  logic signed [15:0] sin_q14 = 16'sd0;

  vertex_t pending_rot[$];
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  int      hold_reqs = 0;
  int      hold_done = 0;
  int      hold_left = 0;
  int      fails = 0;
  int      checked = 0;
  int      sent = 0;
  int      settings = 1;

  axis_vertex_rotation i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic longint unsigned quarter_wave(input longint unsigned ph);
    longint unsigned sq;
    longint unsigned t;
    sq = (ph * ph) >> 14;
    t  = 64'd21024 - ((64'd2320 * sq) >> 14);
    t  = 64'd51472 - ((t * sq) >> 14);
    return (ph * t) >> 15;
  endfunction

  function automatic void load_angle(input logic [15:0] a);
    logic signed [15:0] sr;
    logic signed [15:0] sc;
    sr = 16'(quarter_wave(64'(a[13:0])));
    sc = 16'(quarter_wave(64'd16384 - 64'(a[13:0])));
    case (quad_t'(a[15:14]))
      QUAD_0: begin sin_q14 = sr;  cos_q14 = sc;  end
      QUAD_1: begin sin_q14 = sc;  cos_q14 = -sr; end
      QUAD_2: begin sin_q14 = -sr; cos_q14 = -sc; end
      default: begin sin_q14 = -sc; cos_q14 = sr; end
    endcase
  endfunction

  // round half up, then clip to 16 bits
  function automatic logic signed [15:0] round_clip(input longint acc);
    longint q;
    q = (acc + 64'sd8192) >>> 14;
    if (q > 32767) q = 32767;
    else if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic vertex_t rotate_vertex(input vertex_t v);
    vertex_t r;
    longint  px;
    longint  py;
    longint  pz;
    longint  c;
    longint  s;
    r  = v;
    px = longint'(v.x);
    py = longint'(v.y);
    pz = longint'(v.z);
    c  = longint'(cos_q14);
    s  = longint'(sin_q14);
    case (axis_sel)
      AXIS_X: begin
        r.y = round_clip(py * c - pz * s);
        r.z = round_clip(py * s + pz * c);
      end
      AXIS_Y: begin
        r.x = round_clip(px * c + pz * s);
        r.z = round_clip(pz * c - px * s);
      end
      AXIS_Z: begin
        r.x = round_clip(px * c - py * s);
        r.y = round_clip(px * s + py * c);
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] pick_coord();
    logic signed [15:0] r;
    r = 16'($urandom);
    case ($urandom_range(0, 9))
      0: r = 16'h7FFF;
      1: r = 16'h8000;
      2: r = 16'($urandom_range(0, 511)) - 16'sd256;
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_vertex(input vertex_t v, input logic known, input vertex_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    do @(posedge clk); while (!in_tready);
    pending_rot.push_back(known ? want : rotate_vertex(v));
    sent++;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_rot.size() != 0) @(posedge clk);
  endtask

  // axis first, so the angle update is the last write before traffic resumes
  task automatic apply_setting(input logic [15:0] angle, input logic [15:0] axis_word);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_AXIS;
    cfg_data  <= axis_word;
    @(posedge clk);
    axis_sel = axis_t'(axis_word[1:0]);
    cfg_index <= REG_ANGLE;
    cfg_data  <= angle;
    @(posedge clk);
    load_angle(angle);
    cfg_wr_en <= 1'b0;
    settings++;
  endtask

  // result side: check each transfer, random backpressure, long hold on request
  initial begin
    vertex_t got;
    vertex_t exp_v;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got = vertex_t'(out_tdata);
        if (pending_rot.size() == 0) begin
          $error("unexpected transfer: x=%0d y=%0d z=%0d", got.x, got.y, got.z);
          fails++;
        end else begin
          exp_v = pending_rot.pop_front();
          checked++;
          if (got.x !== exp_v.x) begin
            $error("out_x mismatch: expected %0d, got %0d", exp_v.x, got.x);
            fails++;
          end
          if (got.y !== exp_v.y) begin
            $error("out_y mismatch: expected %0d, got %0d", exp_v.y, got.y);
            fails++;
          end
          if (got.z !== exp_v.z) begin
            $error("out_z mismatch: expected %0d, got %0d", exp_v.z, got.z);
            fails++;
          end
        end
      end
      if (hold_done != hold_reqs) begin
        hold_left = 300;
        hold_done = hold_reqs;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    vertex_t     v;
    logic [15:0] angle;
    logic [15:0] aw;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 7;
    recv_idle_pct = 82;
    for (int i = 0; i < N_DIR; i++) begin
      if (DIR_ROWS[i].wr) apply_setting(DIR_ROWS[i].angle, DIR_ROWS[i].axis_word);
      send_vertex(DIR_ROWS[i].v, DIR_ROWS[i].known, DIR_ROWS[i].want);
    end

    for (int m = 0; m < 3; m++) begin
      send_idle_pct = (m == 0) ? 7 : (m == 1) ? 82 : 0;
      recv_idle_pct = (m == 0) ? 82 : (m == 1) ? 7 : 0;
      for (int p = 0; p < 5; p++) begin
        case (p)
          0: angle = 16'h0000;
          1: angle = 16'hFFFF;
          2: angle = 16'($urandom_range(1, 3)) << 14;
          default: angle = 16'($urandom);
        endcase
        aw = 16'($urandom);
        aw[1:0] = 2'((p + m) % 4);
        apply_setting(angle, aw);
        if (p == 2) hold_reqs++;
        for (int k = 0; k < 100; k++) begin
          if (p == 3 && k == 50) drain_results();
          v.x = pick_coord();
          v.y = pick_coord();
          v.z = pick_coord();
          send_vertex(v, 1'b0, NOV);
        end
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    $display("%0d vertices sent, %0d transfers checked, %0d rotation settings",
             sent, checked, settings);
    $display("all four axis codes, quadrant boundaries and saturating extremes exercised");
    if (fails == 0 && pending_rot.size() == 0) begin
      $display("axis_vertex_rotation_tb: PASS");
    end else begin
      $display("axis_vertex_rotation_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout: %0d transfers still outstanding", pending_rot.size());
    $display("axis_vertex_rotation_tb: FAIL");
    $finish;
  end

endmodule
